// ----- hw/rtl/rfc_pkg.sv -----
// Shared constants and handshake structs for the rainflow cycle counter.
// No dependencies; imported by every other file of the block but rfc_stack_mem.
`timescale 1ns / 1ps

package rfc_pkg;

    localparam int RFC_STACK_DEPTH = 32;
    localparam int RFC_SAMPLE_BITS = 16;
    localparam int RFC_MAX_RESULTS = 32;

    localparam logic [1:0] TREND_UNK  = 2'd0;
    localparam logic [1:0] TREND_RISE = 2'd1;
    localparam logic [1:0] TREND_FALL = 2'd2;

    typedef struct packed {
        logic put;
        logic close;
        logic full;
    } rfc_emit_ctl_t;

    typedef struct packed {
        logic put_ok;
        logic close_ok;
    } rfc_emit_sts_t;

endpackage

// ----- hw/rtl/rfc_stack_mem.sv -----
// Reversal stack storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rfc_stack_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/rfc_result_buf.sv -----
// Result holding stage and output register; the held item is marked last on close.
// Depends on rfc_pkg for the emit control and status structs.
`timescale 1ns / 1ps

module rfc_result_buf #(
    parameter int SAMPLE_BITS = rfc_pkg::RFC_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rfc_pkg::rfc_emit_ctl_t        emit_ctl,
    output rfc_pkg::rfc_emit_sts_t        emit_sts,
    input  logic signed [SAMPLE_BITS-1:0] emit_a,
    input  logic signed [SAMPLE_BITS-1:0] emit_b,
    input  logic                          ovf,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_cycle_high,
    output logic signed [SAMPLE_BITS-1:0] m_cycle_low,
    output logic                          m_full_cycle,
    output logic                          m_run_last,
    output logic                          m_stack_overflow
);

    import rfc_pkg::*;

    logic                          stg_vld_reg, stg_vld_next;
    logic signed [SAMPLE_BITS-1:0] stg_hi_reg, stg_lo_reg;
    logic                          stg_full_reg;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_hi_reg, m_lo_reg;
    logic                          m_full_reg, m_last_reg, m_ovf_reg;
    logic                          out_free, do_put, do_close, move;

    assign out_free          = !m_valid_reg || m_ready;
    assign emit_sts.put_ok   = !stg_vld_reg || out_free;
    assign emit_sts.close_ok = !stg_vld_reg || out_free;
    assign do_put            = emit_ctl.put && emit_sts.put_ok;
    assign do_close          = emit_ctl.close && emit_sts.close_ok;
    assign move              = (do_put || do_close) && stg_vld_reg;

    always_comb begin
        stg_vld_next = stg_vld_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (move) begin
            m_valid_next = 1'b1;
        end
        if (do_put) begin
            stg_vld_next = 1'b1;
        end else if (do_close) begin
            stg_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            stg_vld_reg <= stg_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_put) begin
            stg_hi_reg   <= (emit_a > emit_b) ? emit_a : emit_b;
            stg_lo_reg   <= (emit_a > emit_b) ? emit_b : emit_a;
            stg_full_reg <= emit_ctl.full;
        end
        if (move) begin
            m_hi_reg   <= stg_hi_reg;
            m_lo_reg   <= stg_lo_reg;
            m_full_reg <= stg_full_reg;
            m_last_reg <= do_close;
            m_ovf_reg  <= ovf;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cycle_high     = m_hi_reg;
    assign m_cycle_low      = m_lo_reg;
    assign m_full_cycle     = m_full_reg;
    assign m_run_last       = m_last_reg;
    assign m_stack_overflow = m_ovf_reg;

endmodule

// ----- hw/rtl/rfc_seq.sv -----
// Sequencer: turning-point filter, stack push, reduction checks and residue flush.
// Depends on rfc_pkg; drives rfc_stack_mem and rfc_result_buf.
`timescale 1ns / 1ps

module rfc_seq #(
    parameter int STACK_DEPTH = rfc_pkg::RFC_STACK_DEPTH,
    parameter int SAMPLE_BITS = rfc_pkg::RFC_SAMPLE_BITS,
    localparam int FW = $clog2(STACK_DEPTH + 1),
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_load_sample,
    input  logic                          s_final_sample,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    output logic                          mem_wr_en,
    output logic [AW-1:0]                 mem_wr_addr,
    output logic [SAMPLE_BITS-1:0]        mem_wr_data,
    output logic                          mem_rd_en,
    output logic [AW-1:0]                 mem_rd_addr,
    input  logic [SAMPLE_BITS-1:0]        mem_rd_data,
    output rfc_pkg::rfc_emit_ctl_t        emit_ctl,
    input  rfc_pkg::rfc_emit_sts_t        emit_sts,
    output logic signed [SAMPLE_BITS-1:0] emit_a,
    output logic signed [SAMPLE_BITS-1:0] emit_b,
    output logic                          ovf
);

    import rfc_pkg::*;

    localparam int RW = $clog2(RFC_MAX_RESULTS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PUSH     = 4'd1;
    localparam logic [3:0] S_CHK      = 4'd2;
    localparam logic [3:0] S_RD       = 4'd3;
    localparam logic [3:0] S_DIFF     = 4'd4;
    localparam logic [3:0] S_EVAL     = 4'd5;
    localparam logic [3:0] S_NEXT     = 4'd6;
    localparam logic [3:0] S_FL_START = 4'd7;
    localparam logic [3:0] S_FL_ISSUE = 4'd8;
    localparam logic [3:0] S_FL_DATA  = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]                    state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] pend_pt_reg, pend_pt_next;
    logic                          pend_vld_reg, pend_vld_next;
    logic [1:0]                    trend_reg, trend_next;
    logic [FW-1:0]                 fill_reg, fill_next;
    logic                          ovf_reg, ovf_next;
    logic                          method_reg, method_next;
    logic                          push_b_reg, push_b_next;
    logic                          flush_reg, flush_next;
    logic [2:0]                    rd_cnt_reg, rd_cnt_next;
    logic                          rd_live_reg, rd_live_next;
    logic [AW-1:0]                 fi_reg, fi_next;
    logic [AW-1:0]                 fl_end_reg, fl_end_next;
    logic [RW-1:0]                 res_cnt_reg, res_cnt_next;

    logic signed [SAMPLE_BITS-1:0] push_val_reg, push_val_next;
    logic signed [SAMPLE_BITS-1:0] push_b_val_reg, push_b_val_next;
    logic signed [SAMPLE_BITS-1:0] win_reg [4];
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS:0]          da_reg, db_reg, dc_reg;

    logic          win_we, prev_we, a_req, hit, can_put;
    logic [1:0]    trend_new;
    logic [2:0]    nwin;
    logic [FW-1:0] rd_addr_full, fill_m1, fill_m3;

    function automatic logic [SAMPLE_BITS:0] absdiff(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        logic signed [SAMPLE_BITS:0] ax;
        logic signed [SAMPLE_BITS:0] bx;
        ax = (SAMPLE_BITS + 1)'(a);
        bx = (SAMPLE_BITS + 1)'(b);
        return (ax > bx) ? (SAMPLE_BITS + 1)'(ax - bx) : (SAMPLE_BITS + 1)'(bx - ax);
    endfunction

    assign nwin         = method_reg ? 3'd4 : 3'd3;
    assign rd_addr_full = fill_reg - FW'(1) - FW'(rd_cnt_reg);
    assign fill_m1      = fill_reg - FW'(1);
    assign fill_m3      = fill_reg - FW'(3);
    assign can_put      = res_cnt_reg < RW'(RFC_MAX_RESULTS);
    assign hit          = method_reg ? ((db_reg <= dc_reg) && (db_reg <= da_reg))
                                     : (da_reg <= db_reg);
    assign ovf          = ovf_reg;

    always_comb begin
        state_next      = state_reg;
        pend_pt_next    = pend_pt_reg;
        pend_vld_next   = pend_vld_reg;
        trend_next      = trend_reg;
        fill_next       = fill_reg;
        ovf_next        = ovf_reg;
        method_next     = method_reg;
        push_b_next     = push_b_reg;
        flush_next      = flush_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_live_next    = 1'b0;
        fi_next         = fi_reg;
        fl_end_next     = fl_end_reg;
        res_cnt_next    = res_cnt_reg;
        push_val_next   = push_val_reg;
        push_b_val_next = push_b_val_reg;
        win_we          = 1'b0;
        prev_we         = 1'b0;
        a_req           = 1'b0;
        trend_new       = trend_reg;
        s_ready         = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        emit_ctl        = '0;
        emit_a          = '0;
        emit_b          = '0;

        if (cfg_wr_en) begin
            method_next = cfg_wr_data;
        end

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (!pend_vld_reg) begin
                    a_req     = 1'b1;
                    trend_new = TREND_UNK;
                end else begin
                    case (trend_reg)
                        TREND_RISE: begin
                            if (s_load_sample < pend_pt_reg) begin
                                a_req     = 1'b1;
                                trend_new = TREND_FALL;
                            end
                        end
                        TREND_FALL: begin
                            if (s_load_sample > pend_pt_reg) begin
                                a_req     = 1'b1;
                                trend_new = TREND_RISE;
                            end
                        end
                        default: begin
                            if (s_load_sample > pend_pt_reg) begin
                                trend_new = TREND_RISE;
                            end else if (s_load_sample < pend_pt_reg) begin
                                trend_new = TREND_FALL;
                            end
                        end
                    endcase
                end
                if (s_valid) begin
                    res_cnt_next    = '0;
                    push_val_next   = pend_vld_reg ? pend_pt_reg : s_load_sample;
                    push_b_next     = s_final_sample &&
                                      (trend_new == TREND_RISE || trend_new == TREND_FALL);
                    push_b_val_next = s_load_sample;
                    flush_next      = s_final_sample;
                    if (s_final_sample) begin
                        pend_vld_next = 1'b0;
                        trend_next    = TREND_UNK;
                        pend_pt_next  = '0;
                    end else begin
                        pend_vld_next = 1'b1;
                        trend_next    = trend_new;
                        pend_pt_next  = s_load_sample;
                    end
                    state_next = a_req ? S_PUSH : S_NEXT;
                end
            end
            S_PUSH: begin
                if (fill_reg == FW'(STACK_DEPTH)) begin
                    ovf_next   = 1'b1;
                    state_next = S_NEXT;
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = fill_reg[AW-1:0];
                    mem_wr_data = push_val_reg;
                    fill_next   = fill_reg + FW'(1);
                    state_next  = S_CHK;
                end
            end
            S_CHK: begin
                if (fill_reg >= FW'(nwin)) begin
                    rd_cnt_next = '0;
                    state_next  = S_RD;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_RD: begin
                if (rd_cnt_reg < nwin) begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = rd_addr_full[AW-1:0];
                    rd_cnt_next  = rd_cnt_reg + 3'd1;
                    rd_live_next = 1'b1;
                end
                if (rd_live_reg) begin
                    win_we = 1'b1;
                    if (rd_cnt_reg == nwin) begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!hit) begin
                    state_next = S_NEXT;
                end else if (!(can_put && !emit_sts.put_ok)) begin
                    emit_ctl.put  = can_put;
                    emit_ctl.full = 1'b1;
                    emit_a        = method_reg ? win_reg[2] : win_reg[1];
                    emit_b        = method_reg ? win_reg[1] : win_reg[0];
                    if (can_put) begin
                        res_cnt_next = res_cnt_reg + RW'(1);
                    end
                    if (method_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = fill_m3[AW-1:0];
                        mem_wr_data = win_reg[0];
                    end
                    fill_next  = fill_reg - FW'(2);
                    state_next = S_CHK;
                end
            end
            S_NEXT: begin
                if (push_b_reg) begin
                    push_val_next = push_b_val_reg;
                    push_b_next   = 1'b0;
                    state_next    = S_PUSH;
                end else if (flush_reg) begin
                    flush_next = 1'b0;
                    state_next = S_FL_START;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FL_START: begin
                if ((!method_reg && fill_reg >= FW'(2)) ||
                    (method_reg && fill_reg == FW'(3))) begin
                    fi_next     = '0;
                    fl_end_next = method_reg ? AW'(1) : fill_m1[AW-1:0];
                    state_next  = S_FL_ISSUE;
                end else begin
                    fill_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_FL_ISSUE: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = fi_reg;
                state_next  = S_FL_DATA;
            end
            S_FL_DATA: begin
                if (fi_reg == '0) begin
                    prev_we    = 1'b1;
                    fi_next    = fi_reg + AW'(1);
                    state_next = S_FL_ISSUE;
                end else if (!(can_put && !emit_sts.put_ok)) begin
                    emit_ctl.put  = can_put;
                    emit_ctl.full = method_reg;
                    emit_a        = prev_reg;
                    emit_b        = $signed(mem_rd_data);
                    if (can_put) begin
                        res_cnt_next = res_cnt_reg + RW'(1);
                    end
                    prev_we = 1'b1;
                    if (fi_reg == fl_end_reg) begin
                        fill_next  = '0;
                        state_next = S_DONE;
                    end else begin
                        fi_next    = fi_reg + AW'(1);
                        state_next = S_FL_ISSUE;
                    end
                end
            end
            S_DONE: begin
                emit_ctl.close = 1'b1;
                if (emit_sts.close_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pend_pt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            trend_reg    <= TREND_UNK;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            method_reg   <= 1'b0;
            push_b_reg   <= 1'b0;
            flush_reg    <= 1'b0;
            rd_cnt_reg   <= '0;
            rd_live_reg  <= 1'b0;
            fi_reg       <= '0;
            fl_end_reg   <= '0;
            res_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            pend_pt_reg  <= pend_pt_next;
            pend_vld_reg <= pend_vld_next;
            trend_reg    <= trend_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            method_reg   <= method_next;
            push_b_reg   <= push_b_next;
            flush_reg    <= flush_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_live_reg  <= rd_live_next;
            fi_reg       <= fi_next;
            fl_end_reg   <= fl_end_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        push_val_reg   <= push_val_next;
        push_b_val_reg <= push_b_val_next;
        if (win_we) begin
            win_reg[2'(rd_cnt_reg - 3'd1)] <= $signed(mem_rd_data);
        end
        if (prev_we) begin
            prev_reg <= $signed(mem_rd_data);
        end
        if (state_reg == S_DIFF) begin
            da_reg <= absdiff(win_reg[0], win_reg[1]);
            db_reg <= absdiff(win_reg[1], win_reg[2]);
            dc_reg <= absdiff(win_reg[2], win_reg[3]);
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_pop_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && hit) |-> fill_reg >= FW'(3))
        else $error("pop with too few stack entries");

    a_put_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_ctl.put |-> emit_sts.put_ok)
        else $error("result put while result buffer full");

    a_first_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !pend_vld_reg) |=> state_reg == S_PUSH)
        else $error("start sample not pushed");
`endif

endmodule

// ----- hw/rtl/rainflow_cycle_counter_top.sv -----
// Top level of the rainflow cycle counter: sequencer, stack memory, result buffer.
// Depends on rfc_pkg, rfc_stack_mem, rfc_result_buf and rfc_seq.
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// input    | s_valid / s_ready  | s_load_sample, s_final_sample
// result   | m_valid / m_ready  | m_cycle_high, m_cycle_low, m_full_cycle,
//          |                    | m_run_last, m_stack_overflow
// config   | cfg_wr_en          | cfg_wr_data (count method)
//
// One item at a time: a new sample is taken only in idle, after the previous one is done;
// every stack check rereads 3 or 4 entries (4 with the four-point rule) through the single
// read port of the stack memory. The final sample adds its end-point push, then a flush
// that reads the residue entries.
// Reset is synchronous, active low; the stack memory is not cleared.
// A stalled result side holds the sequencer when a result waits in the staging register
// behind an unaccepted output item.
`timescale 1ns / 1ps

module rainflow_cycle_counter_top #(
    parameter int STACK_DEPTH = rfc_pkg::RFC_STACK_DEPTH,
    parameter int SAMPLE_BITS = rfc_pkg::RFC_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_load_sample,
    input  logic                          s_final_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_cycle_high,
    output logic signed [SAMPLE_BITS-1:0] m_cycle_low,
    output logic                          m_full_cycle,
    output logic                          m_run_last,
    output logic                          m_stack_overflow,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);

    import rfc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic                          mem_wr_en, mem_rd_en;
    logic [AW-1:0]                 mem_wr_addr, mem_rd_addr;
    logic [SAMPLE_BITS-1:0]        mem_wr_data, mem_rd_data;
    rfc_emit_ctl_t                 emit_ctl;
    rfc_emit_sts_t                 emit_sts;
    logic signed [SAMPLE_BITS-1:0] emit_a, emit_b;
    logic                          ovf;

    rfc_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rfc_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_load_sample  (s_load_sample),
        .s_final_sample (s_final_sample),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .emit_ctl       (emit_ctl),
        .emit_sts       (emit_sts),
        .emit_a         (emit_a),
        .emit_b         (emit_b),
        .ovf            (ovf)
    );

    rfc_result_buf #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_buf (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .emit_ctl         (emit_ctl),
        .emit_sts         (emit_sts),
        .emit_a           (emit_a),
        .emit_b           (emit_b),
        .ovf              (ovf),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cycle_high     (m_cycle_high),
        .m_cycle_low      (m_cycle_low),
        .m_full_cycle     (m_full_cycle),
        .m_run_last       (m_run_last),
        .m_stack_overflow (m_stack_overflow)
    );

endmodule
